// ===== rtl/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine: shared package
// Operation codes, field widths and fixed constants of the console block.
// ----------------------------------------------------------------------------
package tcce_pkg;

   localparam int OP_W     = 3;
   localparam int CHAR_W   = 16;
   localparam int COLOR_W  = 8;
   localparam int NIBBLE_W = 4;
   localparam int TAB_W    = 4;
   localparam int POS_W    = 6;
   localparam int CUR_W    = 5;

   localparam logic [CHAR_W-1:0] SPACE_CHAR = 16'h0020;
   localparam logic [TAB_W-1:0]  TAB_RESET  = 4'd4;

   typedef enum logic [OP_W-1:0] {
      OP_PUT        = 3'd0,
      OP_NEWLINE    = 3'd1,
      OP_TAB        = 3'd2,
      OP_LOCATE     = 3'd3,
      OP_COLOR_BOTH = 3'd4,
      OP_COLOR_FG   = 3'd5,
      OP_CLEAR      = 3'd6,
      OP_READ       = 3'd7
   } op_type;

endpackage

// ===== rtl/tcce_cell_store.sv =====
// ----------------------------------------------------------------------------
// Text console cell store
// Character and color memories sharing one write port and one read port,
// read data registered.
// ----------------------------------------------------------------------------
module tcce_cell_store #(
   parameter int DEPTH = 768,
   parameter int AW    = 10
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [tcce_pkg::CHAR_W-1:0]  wr_char,
   input  logic [tcce_pkg::COLOR_W-1:0] wr_color,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic [tcce_pkg::CHAR_W-1:0]  rd_char,
   output logic [tcce_pkg::COLOR_W-1:0] rd_color
);
   import tcce_pkg::*;

   logic [CHAR_W-1:0]  char_mem_ff  [DEPTH];
   logic [COLOR_W-1:0] color_mem_ff [DEPTH];
   logic [CHAR_W-1:0]  rd_char_ff;
   logic [COLOR_W-1:0] rd_color_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         char_mem_ff[wr_addr]  <= wr_char;
         color_mem_ff[wr_addr] <= wr_color;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_char_ff  <= char_mem_ff[rd_addr];
         rd_color_ff <= color_mem_ff[rd_addr];
      end
   end

   assign rd_char  = rd_char_ff;
   assign rd_color = rd_color_ff;

endmodule

// ===== rtl/tcce_tab_mod.sv =====
// ----------------------------------------------------------------------------
// Text console tab remainder unit
// Restoring remainder of the cursor column by the tab step, one bit a cycle.
// ----------------------------------------------------------------------------
module tcce_tab_mod #(
   parameter int XW = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [XW-1:0]               x_value,
   input  logic [tcce_pkg::TAB_W-1:0]  step,
   output logic                        done,
   output logic [tcce_pkg::TAB_W-1:0]  rem
);
   import tcce_pkg::*;

   localparam int KW = $clog2(XW + 1);
   localparam logic [KW-1:0] K_FULL = KW'(XW);
   localparam logic [KW-1:0] K_ONE  = KW'(1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [KW-1:0]     cnt_ff, cnt_in;
   logic [XW-1:0]     bits_ff, bits_in;
   logic [TAB_W-1:0]  rem_ff, rem_in;
   logic [TAB_W:0]    shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      bits_in = bits_ff;
      rem_in  = rem_ff;
      shifted = {rem_ff, bits_ff[XW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = K_FULL;
         bits_in = x_value;
         rem_in  = '0;
      end else if (busy_ff) begin
         // The partial remainder stays below the step, so it fits in a nibble.
         if (shifted >= {1'b0, step}) begin
            rem_in = TAB_W'(shifted - {1'b0, step});
         end else begin
            rem_in = shifted[TAB_W-1:0];
         end
         bits_in = bits_ff << 1;
         cnt_in  = cnt_ff - K_ONE;
         if (cnt_ff == K_ONE) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      bits_ff <= bits_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

// ===== rtl/text_console_cursor_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine
// Character-cell screen with cursor, current color, deferred scroll, tab,
// locate, clear and cell read. Cells live in a one-port-write, one-port-read
// synchronous store; a sequencer reads, moves and writes them.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                               Direction  Handshake
//   --------  ----------------------------------  ---------  -----------------
//   request   start, busy, req_*                  in         start && !busy
//   response  rsp_valid, rsp_*                    out        strobe, no stall
//   csr       csr_valid, csr_ready, csr_tab_step  in         valid && ready
//
// Locate and color operations complete in the accept cycle; a read waits for
// the registered store data and a put writes one cell. A scroll reads each
// moved cell and writes every cell, a tab finds the column remainder bit by
// bit and then writes spaces up to the next tab stop, and a clear writes every
// cell. The response strobe comes in the cycle after the operation completes
// and cannot be stalled. After reset the block sweeps the whole store to zero
// with busy high; csr transfers are taken at all times.
//
module text_console_cursor_engine_unit #(
   parameter int COLUMNS = 32,
   parameter int ROWS    = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   // request
   input  logic                          start,
   output logic                          busy,
   input  logic [tcce_pkg::OP_W-1:0]     req_operation,
   input  logic [tcce_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tcce_pkg::POS_W-1:0]    req_target_col,
   input  logic [tcce_pkg::POS_W-1:0]    req_target_row,
   input  logic [tcce_pkg::NIBBLE_W-1:0] req_fore_color,
   input  logic [tcce_pkg::NIBBLE_W-1:0] req_back_color,
   // response
   output logic                          rsp_valid,
   output logic [tcce_pkg::CUR_W-1:0]    rsp_cursor_col,
   output logic [tcce_pkg::CUR_W-1:0]    rsp_cursor_row,
   output logic [tcce_pkg::CHAR_W-1:0]   rsp_cell_char,
   output logic [tcce_pkg::COLOR_W-1:0]  rsp_cell_color,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tcce_pkg::TAB_W-1:0]    csr_tab_step
);
   import tcce_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CNTW  = $clog2(CELLS + 1);
   localparam int CW    = $clog2(COLUMNS);
   // The row register must hold ROWS + 1 for a newline with a scroll pending.
   localparam int RW    = $clog2(ROWS + 2);

   localparam logic [CW-1:0]   LAST_COL  = CW'(COLUMNS - 1);
   localparam logic [RW-1:0]   ROW_LIM   = RW'(ROWS);
   localparam logic [RW-1:0]   ROW_ONE   = RW'(1);
   localparam logic [CNTW-1:0] CNT_CELLS = CNTW'(CELLS);
   localparam logic [CNTW-1:0] CNT_LAST  = CNTW'(CELLS - 1);
   localparam logic [CNTW-1:0] CNT_MOVE  = CNTW'(CELLS - COLUMNS);
   localparam logic [CNTW-1:0] CNT_COLS  = CNTW'(COLUMNS);
   localparam logic [CNTW-1:0] CNT_ONE   = CNTW'(1);
   localparam logic [TAB_W-1:0] TAB_ONE  = TAB_W'(1);

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_TABMOD = 7'b0000100,
      S_PREP   = 7'b0001000,
      S_SCROLL = 7'b0010000,
      S_PUT    = 7'b0100000,
      S_READ   = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in, req_op;
   logic [CW-1:0]      cursor_x_ff, cursor_x_in;
   logic [RW-1:0]      cursor_y_ff, cursor_y_in;
   logic [COLOR_W-1:0] cur_color_ff, cur_color_in;
   logic [TAB_W-1:0]   tab_step_ff, tab_step_in;
   logic [TAB_W-1:0]   step_ff, step_in;
   logic [TAB_W-1:0]   rem_ff, rem_in;
   logic [TAB_W-1:0]   rem_next;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic [CNTW-1:0]    cnt_ff, cnt_in;
   logic               rd_ok_ff, rd_ok_in;
   logic               clr_reply_ff, clr_reply_in;
   logic               rsp_valid_ff, finish;
   logic [CUR_W-1:0]   rsp_col_ff, rsp_row_ff;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;

   logic               accept, in_range;
   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [CHAR_W-1:0]  mem_wchar, mem_rchar;
   logic [COLOR_W-1:0] mem_wcolor, mem_rcolor;
   logic               mod_start, mod_done;
   logic [TAB_W-1:0]   mod_rem;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign req_op    = op_type'(req_operation);
   assign in_range  = ({1'b0, req_target_col} < 7'(COLUMNS))
                   && ({1'b0, req_target_row} < 7'(ROWS));

   tcce_cell_store #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_store (
      .clock    (clock),
      .wr_en    (mem_we),
      .wr_addr  (mem_waddr),
      .wr_char  (mem_wchar),
      .wr_color (mem_wcolor),
      .rd_en    (mem_re),
      .rd_addr  (mem_raddr),
      .rd_char  (mem_rchar),
      .rd_color (mem_rcolor)
   );

   tcce_tab_mod #(
      .XW (CW)
   ) u_tab_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .x_value (cursor_x_ff),
      .step    (step_ff),
      .done    (mod_done),
      .rem     (mod_rem)
   );

   // The tab loop tracks column modulo step; a wrap to column zero also ends it.
   assign rem_next = ((rem_ff + TAB_ONE) == step_ff) ? '0 : (rem_ff + TAB_ONE);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      cur_color_in = cur_color_ff;
      tab_step_in  = csr_valid ? csr_tab_step : tab_step_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      char_in      = char_ff;
      cnt_in       = cnt_ff;
      rd_ok_in     = rd_ok_ff;
      clr_reply_in = clr_reply_ff;
      finish       = 1'b0;
      rsp_char_in  = '0;
      rsp_color_in = '0;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wchar    = '0;
      mem_wcolor   = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      mod_start    = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            // Sweep the store to zero, one cell a cycle.
            mem_we    = 1'b1;
            mem_waddr = AW'(cnt_ff);
            if (cnt_ff == CNT_LAST) begin
               state_in     = S_IDLE;
               finish       = clr_reply_ff;
               clr_reply_in = 1'b0;
            end else begin
               cnt_in = cnt_ff + CNT_ONE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in   = req_op;
               char_in = req_char_code;
               step_in = (tab_step_ff == '0) ? TAB_ONE : tab_step_ff;
               case (req_op)
                  OP_PUT: begin
                     state_in = S_PREP;
                  end
                  OP_NEWLINE: begin
                     cursor_x_in = '0;
                     cursor_y_in = cursor_y_ff + ROW_ONE;
                     state_in    = S_PREP;
                  end
                  OP_TAB: begin
                     mod_start = 1'b1;
                     state_in  = S_TABMOD;
                  end
                  OP_LOCATE: begin
                     if (in_range) begin
                        cursor_x_in = CW'(req_target_col);
                        cursor_y_in = RW'(req_target_row);
                     end
                     finish = 1'b1;
                  end
                  OP_COLOR_BOTH: begin
                     cur_color_in = {req_back_color, req_fore_color};
                     finish       = 1'b1;
                  end
                  OP_COLOR_FG: begin
                     cur_color_in = {cur_color_ff[COLOR_W-1:NIBBLE_W], req_fore_color};
                     finish       = 1'b1;
                  end
                  OP_CLEAR: begin
                     cursor_x_in  = '0;
                     cursor_y_in  = '0;
                     cnt_in       = '0;
                     clr_reply_in = 1'b1;
                     state_in     = S_CLEAR;
                  end
                  OP_READ: begin
                     mem_re    = 1'b1;
                     mem_raddr = AW'(req_target_row * COLUMNS + req_target_col);
                     rd_ok_in  = in_range;
                     state_in  = S_READ;
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         S_TABMOD: begin
            if (mod_done) begin
               rem_in   = mod_rem;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            // A row at or past the bottom means a scroll comes first.
            if (cursor_y_ff >= ROW_LIM) begin
               cnt_in   = '0;
               state_in = S_SCROLL;
            end else if (op_ff == OP_NEWLINE) begin
               finish   = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_PUT;
            end
         end
         S_SCROLL: begin
            // Read one row ahead, write back in the following cycle; the bottom row
            // gets zero characters in the current color.
            mem_re    = (cnt_ff < CNT_MOVE);
            mem_raddr = AW'(cnt_ff + CNT_COLS);
            mem_we    = (cnt_ff != '0);
            mem_waddr = AW'(cnt_ff - CNT_ONE);
            if (cnt_ff <= CNT_MOVE) begin
               mem_wchar  = mem_rchar;
               mem_wcolor = mem_rcolor;
            end else begin
               mem_wchar  = '0;
               mem_wcolor = cur_color_ff;
            end
            if (cnt_ff == CNT_CELLS) begin
               cursor_y_in = cursor_y_ff - ROW_ONE;
               state_in    = S_PREP;
            end else begin
               cnt_in = cnt_ff + CNT_ONE;
            end
         end
         S_PUT: begin
            mem_we     = 1'b1;
            mem_waddr  = AW'(cursor_y_ff * COLUMNS + cursor_x_ff);
            mem_wchar  = (op_ff == OP_PUT) ? char_ff : SPACE_CHAR;
            mem_wcolor = cur_color_ff;
            if (cursor_x_ff == LAST_COL) begin
               cursor_x_in = '0;
               cursor_y_in = cursor_y_ff + ROW_ONE;
            end else begin
               cursor_x_in = cursor_x_ff + CW'(1);
            end
            if (op_ff == OP_PUT || cursor_x_ff == LAST_COL || rem_next == '0) begin
               finish   = 1'b1;
               state_in = S_IDLE;
            end else begin
               rem_in   = rem_next;
               state_in = S_PREP;
            end
         end
         S_READ: begin
            if (rd_ok_ff) begin
               rsp_char_in  = mem_rchar;
               rsp_color_in = mem_rcolor;
            end
            finish   = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         cur_color_ff <= '0;
         tab_step_ff  <= TAB_RESET;
         cnt_ff       <= '0;
         clr_reply_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         cur_color_ff <= cur_color_in;
         tab_step_ff  <= tab_step_in;
         cnt_ff       <= cnt_in;
         clr_reply_ff <= clr_reply_in;
         rsp_valid_ff <= finish;
      end
      op_ff        <= op_in;
      step_ff      <= step_in;
      rem_ff       <= rem_in;
      char_ff      <= char_in;
      rd_ok_ff     <= rd_ok_in;
      rsp_col_ff   <= CUR_W'(cursor_x_in);
      rsp_row_ff   <= CUR_W'(cursor_y_in);
      rsp_char_ff  <= rsp_char_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_color = rsp_color_ff;

   // The column never reaches COLUMNS.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      cursor_x_ff <= LAST_COL)
      else $error("cursor column out of range");

   // Between operations the row is at most ROWS (scroll pending).
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> cursor_y_ff <= ROW_LIM)
      else $error("cursor row past pending-scroll position");

   // An accepted operation either responds or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted operation neither responded nor went busy");

   // The clearing pass after reset gives no response.
   a_clear_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(state_ff) == S_CLEAR |-> $past(clr_reply_ff))
      else $error("response from the reset clearing pass");

endmodule
